FILE: rtl/psa_pkg.sv
// Shared types, codes and field widths for the positional slot array.
`default_nettype none

package psa_pkg;

	localparam int CAPACITY_DEF  = 256;
	localparam int WORD_BITS_DEF = 32;

	localparam int OP_W     = 3;
	localparam int POS_W    = 8;
	localparam int DATA_W   = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 9;
	localparam int CHANGE_W = 32;

	typedef enum logic [OP_W-1:0] {
		OP_READ   = 3'd0,
		OP_WRITE  = 3'd1,
		OP_APPEND = 3'd2,
		OP_INSERT = 3'd3,
		OP_CUT    = 3'd4,
		OP_CLEAR  = 3'd5
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_INDEX = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// What every cell of the row does in the current cycle.
	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_WRITE  = 2'd1,
		CELL_INSERT = 2'd2,
		CELL_CUT    = 2'd3
	} cell_op_t;

endpackage

`default_nettype wire

FILE: rtl/psa_req_if.sv
// Request channel: valid, ready and the request word.
`default_nettype none

interface psa_req_if;
	import psa_pkg::*;

	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   op;
	logic [POS_W-1:0]  position;
	logic [DATA_W-1:0] data_word;

	modport source (output valid, output op, output position, output data_word, input ready);
	modport sink   (input valid, input op, input position, input data_word, output ready);
endinterface

`default_nettype wire

FILE: rtl/psa_rsp_if.sv
// Response channel: valid, ready and the result word.
`default_nettype none

interface psa_rsp_if;
	import psa_pkg::*;

	logic                valid;
	logic                ready;
	logic [DATA_W-1:0]   read_word;
	logic [POS_W-1:0]    placed_at;
	logic [STATUS_W-1:0] status;
	logic [COUNT_W-1:0]  entry_count;
	logic [CHANGE_W-1:0] change_count;

	modport source (output valid, output read_word, output placed_at, output status,
		output entry_count, output change_count, input ready);
	modport sink   (input valid, input read_word, input placed_at, input status,
		input entry_count, input change_count, output ready);
endinterface

`default_nettype wire

FILE: rtl/psa_cell.sv
// One entry of the row: holds a word, or takes it from a neighbour or the bus.
`default_nettype none

module psa_cell #(
	parameter int WORD_BITS = psa_pkg::WORD_BITS_DEF,
	parameter int IDX_W     = 8,
	parameter int INDEX     = 0
) (
	input  wire logic                 clk,
	input  wire psa_pkg::cell_op_t    cell_op,
	input  wire logic [IDX_W-1:0]     cell_pos,
	input  wire logic [WORD_BITS-1:0] word,
	input  wire logic [WORD_BITS-1:0] left,
	input  wire logic [WORD_BITS-1:0] right,
	output logic      [WORD_BITS-1:0] q
);
	import psa_pkg::*;

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

	logic [WORD_BITS-1:0] entry_q;
	logic [WORD_BITS-1:0] entry_d;

	always_comb begin
		entry_d = entry_q;
		unique case (cell_op)
			CELL_WRITE: begin
				if (MY_IDX == cell_pos) entry_d = word;
			end
			CELL_INSERT: begin
				if (MY_IDX == cell_pos) entry_d = word;
				else if (MY_IDX > cell_pos) entry_d = left;
			end
			CELL_CUT: begin
				if (MY_IDX >= cell_pos) entry_d = right;
			end
			default: begin
				entry_d = entry_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

	assign q = entry_q;

endmodule

`default_nettype wire

FILE: rtl/psa_row.sv
// The row of cells, chained to both neighbours, with the read selector.
`default_nettype none

module psa_row #(
	parameter int CAPACITY  = psa_pkg::CAPACITY_DEF,
	parameter int WORD_BITS = psa_pkg::WORD_BITS_DEF,
	parameter int IDX_W     = 8
) (
	input  wire logic                 clk,
	input  wire psa_pkg::cell_op_t    cell_op,
	input  wire logic [IDX_W-1:0]     cell_pos,
	input  wire logic [WORD_BITS-1:0] word,
	input  wire logic [IDX_W-1:0]     rd_idx,
	output logic      [WORD_BITS-1:0] rd_word
);
	import psa_pkg::*;

	logic [CAPACITY-1:0][WORD_BITS-1:0] cell_q;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [WORD_BITS-1:0] left;
		logic [WORD_BITS-1:0] right;

		// The ends of the row see zero beyond them.
		if (i == 0) begin : g_first
			assign left = '0;
		end else begin : g_inner_l
			assign left = cell_q[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right = '0;
		end else begin : g_inner_r
			assign right = cell_q[i+1];
		end

		psa_cell #(
			.WORD_BITS (WORD_BITS),
			.IDX_W     (IDX_W),
			.INDEX     (i)
		) u_cell (
			.clk      (clk),
			.cell_op  (cell_op),
			.cell_pos (cell_pos),
			.word     (word),
			.left     (left),
			.right    (right),
			.q        (cell_q[i])
		);
	end

	assign rd_word = cell_q[rd_idx];

endmodule

`default_nettype wire

FILE: rtl/positional_slot_array.sv
// Positional slot array: an ordered row of words with insert, cut and a change counter.
//
// Each request word on req carries an op, a position and a data word; each one
// yields exactly one response word on rsp with the read word, the append
// position, a status code, the entry count and the change counter after it.
// A request is accepted when req.valid and req.ready are both high.
// The response word is loaded into the output register at the accepting edge and
// offered on rsp from the following cycle. Throughput is one request per cycle
// while the receiver does not stall rsp, set by the row of cells, which shifts
// all entries up or down in parallel for an insert or a cut.
// req.ready is high while the output register is empty or being emptied in
// the same cycle, so a stalled receiver holds the response word and blocks
// only the next request.
// Reset clears the fill count, the change counter and the output valid; the
// stored entries are not cleared and are never visible before being written.
`default_nettype none

module positional_slot_array #(
	parameter int CAPACITY  = psa_pkg::CAPACITY_DEF,
	parameter int WORD_BITS = psa_pkg::WORD_BITS_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	psa_req_if.sink    req,
	psa_rsp_if.source  rsp
);
	import psa_pkg::*;

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int PW    = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
	localparam logic [PW-1:0] CAP_X = PW'(CAPACITY);

	logic [CNT_W-1:0]    fill_q;
	logic [CHANGE_W-1:0] mod_q;
	logic                valid_q;
	logic [DATA_W-1:0]   read_word_q;
	logic [POS_W-1:0]    placed_q;
	status_t             status_q;

	logic                 fire;
	logic [PW-1:0]        pos_x;
	logic [PW-1:0]        fill_x;
	logic [PW-1:0]        fill_d;
	logic                 in_range;
	logic                 full;
	logic                 mod_inc;
	logic                 rd_ok;
	status_t              status_d;
	logic [POS_W-1:0]     placed_d;
	cell_op_t             cell_op;
	cell_op_t             cell_op_eff;
	logic [IDX_W-1:0]     cell_pos;
	logic [63:0]          data_ext;
	logic [WORD_BITS-1:0] word_in;
	logic [WORD_BITS-1:0] rd_cell;
	logic [63:0]          rd_ext;

	assign req.ready = !valid_q || rsp.ready;
	assign fire      = req.valid && req.ready;

	assign pos_x    = PW'(req.position);
	assign fill_x   = PW'(fill_q);
	assign in_range = pos_x < fill_x;
	assign full     = fill_x == CAP_X;

	assign data_ext = 64'(req.data_word);
	assign word_in  = data_ext[WORD_BITS-1:0];
	assign rd_ext   = 64'(rd_cell);

	always_comb begin
		fill_d   = fill_x;
		mod_inc  = 1'b0;
		rd_ok    = 1'b0;
		status_d = ST_OK;
		placed_d = '0;
		cell_op  = CELL_HOLD;
		cell_pos = pos_x[IDX_W-1:0];
		unique case (op_t'(req.op))
			OP_READ: begin
				if (in_range) rd_ok = 1'b1;
				else status_d = ST_INDEX;
			end
			OP_WRITE: begin
				if (in_range) begin
					cell_op = CELL_WRITE;
					mod_inc = 1'b1;
				end else begin
					status_d = ST_INDEX;
				end
			end
			OP_APPEND: begin
				mod_inc = 1'b1;
				if (full) begin
					status_d = ST_FULL;
				end else begin
					cell_op  = CELL_WRITE;
					cell_pos = fill_x[IDX_W-1:0];
					placed_d = fill_x[POS_W-1:0];
					fill_d   = fill_x + PW'(1);
				end
			end
			OP_INSERT: begin
				mod_inc = 1'b1;
				if (full) begin
					status_d = ST_FULL;
				end else if (pos_x > fill_x) begin
					status_d = ST_INDEX;
				end else begin
					cell_op = CELL_INSERT;
					fill_d  = fill_x + PW'(1);
				end
			end
			OP_CUT: begin
				if (in_range) begin
					cell_op = CELL_CUT;
					mod_inc = 1'b1;
					fill_d  = fill_x - PW'(1);
				end else begin
					status_d = ST_INDEX;
				end
			end
			OP_CLEAR: begin
				mod_inc = 1'b1;
				fill_d  = '0;
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	assign cell_op_eff = fire ? cell_op : CELL_HOLD;

	psa_row #(
		.CAPACITY  (CAPACITY),
		.WORD_BITS (WORD_BITS),
		.IDX_W     (IDX_W)
	) u_row (
		.clk      (clk),
		.cell_op  (cell_op_eff),
		.cell_pos (cell_pos),
		.word     (word_in),
		.rd_idx   (pos_x[IDX_W-1:0]),
		.rd_word  (rd_cell)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			mod_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (fire) begin
				fill_q <= fill_d[CNT_W-1:0];
				if (mod_inc) mod_q <= mod_q + CHANGE_W'(1);
				valid_q <= 1'b1;
			end else if (rsp.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			read_word_q <= rd_ok ? rd_ext[DATA_W-1:0] : '0;
			placed_q    <= placed_d;
			status_q    <= status_d;
		end
	end

	// The count and counter registers only move on acceptance, so they always
	// match the response word held in the output register.
	assign rsp.valid        = valid_q;
	assign rsp.read_word    = read_word_q;
	assign rsp.placed_at    = placed_q;
	assign rsp.status       = status_q;
	assign rsp.entry_count  = fill_x[COUNT_W-1:0];
	assign rsp.change_count = mod_q;

endmodule

`default_nettype wire
